>>> src/packed_glyph_pixel_unpacker_core_macros.svh
// Assertion macros used by the glyph pixel unpacker sources (pgpu_unpack).
`ifndef PACKED_GLYPH_PIXEL_UNPACKER_CORE_MACROS_SVH
`define PACKED_GLYPH_PIXEL_UNPACKER_CORE_MACROS_SVH

`ifndef SYNTH
// Check outside of reset.
`define PGPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pgpu assertion failed");
// Check at every edge, reset included.
`define PGPU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pgpu assertion failed");
`else
`define PGPU_ASSERT(lbl, clk, rstn, prop)
`define PGPU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/pgpu_pkg.sv
`default_nettype none

package pgpu_pkg;

  localparam int unsigned MaxGlyphDimDefault = 256;

  localparam int unsigned DataW    = 8;   // one bitmap byte
  localparam int unsigned PosW     = 8;   // pixel_col / pixel_row on the bus
  localparam int unsigned GrayW    = 8;
  localparam int unsigned DepthW   = 3;
  localparam int unsigned DimW     = 9;   // glyph_cols / glyph_rows registers
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 9;   // widest register
  localparam int unsigned BufW     = 15;  // 7 leftover bits + one byte
  localparam int unsigned LeftW    = 7;
  localparam int unsigned CntW     = 4;   // bit count in the buffer, up to 15
  localparam int unsigned OutDataW = GrayW + 2 * PosW;

  localparam logic [CntW-1:0] LeftMax  = CntW'(7);
  localparam logic [CntW-1:0] ByteBits = CntW'(8);
  localparam logic [GrayW-1:0] White   = 8'hFF;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DEPTH_CODE = 4'd0,
    CFG_NIBBLE     = 4'd1,
    CFG_COLS       = 4'd2,
    CFG_ROWS       = 4'd3
  } cfg_addr_e;

  // Unused codes above DEPTH_8 behave as 8 bits per pixel.
  typedef enum logic [DepthW-1:0] {
    DEPTH_1 = 3'd0,
    DEPTH_2 = 3'd1,
    DEPTH_3 = 3'd2,
    DEPTH_4 = 3'd3,
    DEPTH_8 = 3'd4
  } depth_e;

  typedef struct packed {
    logic [DepthW-1:0] depth_code;
    logic              nibble_aligned_three;
    logic [DimW-1:0]   glyph_cols;
    logic [DimW-1:0]   glyph_rows;
  } cfg_t;

  // Raw pixel from the unpack stage, before gray conversion.
  typedef struct packed {
    logic [DataW-1:0]  value;
    logic [DepthW-1:0] depth_code;
    logic [PosW-1:0]   col;
    logic [PosW-1:0]   row;
    logic              run_end;
    logic              glyph_end;
  } pix_t;

  function automatic logic [CntW-1:0] pix_bits(input logic [DepthW-1:0] depth);
    logic [CntW-1:0] b;
    case (depth)
      DEPTH_1: b = CntW'(1);
      DEPTH_2: b = CntW'(2);
      DEPTH_3: b = CntW'(3);
      DEPTH_4: b = CntW'(4);
      default: b = CntW'(8);
    endcase
    return b;
  endfunction

  // 255 - v*255/(2^bpp-1), v first masked to bpp bits.
  function automatic logic [GrayW-1:0] gray_of(input logic [DataW-1:0]  v,
                                               input logic [DepthW-1:0] depth);
    logic [GrayW-1:0] g;
    case (depth)
      DEPTH_1: g = v[0] ? 8'd0 : White;
      DEPTH_2: g = White - 8'({6'd0, v[1:0]} * 8'd85);
      DEPTH_3: begin
        case (v[2:0])
          3'd0:    g = 8'd255;
          3'd1:    g = 8'd219;
          3'd2:    g = 8'd183;
          3'd3:    g = 8'd146;
          3'd4:    g = 8'd110;
          3'd5:    g = 8'd73;
          3'd6:    g = 8'd37;
          default: g = 8'd0;
        endcase
      end
      DEPTH_4: g = White - 8'({4'd0, v[3:0]} * 8'h11);
      default: g = ~v;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> src/packed_glyph_pixel_unpacker_core.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid_i/tready_o     tdata: data_byte; tlast: final_byte
// m_axis    out        m_axis_tvalid_o/tready_i     tdata: gray, col, row; tlast: glyph_end;
//                                                   tuser: run_end
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_addr_i: register, cfg_data_i: value
//
// The unpack stage emits the pixels of each accepted byte one at a time: 8 at 1 bpp,
// 4 at 2 bpp, 2 or 3 at 3 bpp, 2 at 4 bpp, 1 at 8 bpp, plus one tail pixel on a final
// byte that ends mid-pixel; its single extraction slot holds one byte at a time.
// A byte that yields nothing (zero size, glyph already complete) is accepted and dropped.
// The next byte is taken in the cycle the current byte's last pixel leaves the
// unpack stage; a stalled m_axis holds the result register and backs up s_axis.
// Reset clears the configuration, the stream position and both valid flags.
`default_nettype none

module packed_glyph_pixel_unpacker_core
  import pgpu_pkg::*;
#(
  parameter int unsigned MaxGlyphDim = MaxGlyphDimDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // bitmap bytes
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [DataW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                s_axis_tlast_i,   // final_byte
  // pixels
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,   // [7:0] gray_level, [15:8] pixel_col,
                                                     // [23:16] pixel_row
  output logic                     m_axis_tlast_o,   // glyph_end
  output logic                     m_axis_tuser_o,   // run_end
  // register writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  logic  cfg_fire, cfg_clear;
  logic  pix_valid, pix_ready;
  pix_t  pix;

  // Registers are always writable; the user, not the block, must keep it idle whenever one is written.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Decode the write; any known register also restarts the glyph stream.
  always_comb begin
    cfg_d     = cfg_q;
    cfg_clear = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_addr_i)
        CFG_DEPTH_CODE: begin
          cfg_d.depth_code = cfg_data_i[DepthW-1:0];
          cfg_clear        = 1'b1;
        end
        CFG_NIBBLE: begin
          cfg_d.nibble_aligned_three = cfg_data_i[0];
          cfg_clear                  = 1'b1;
        end
        CFG_COLS: begin
          cfg_d.glyph_cols = cfg_data_i[DimW-1:0];
          cfg_clear        = 1'b1;
        end
        CFG_ROWS: begin
          cfg_d.glyph_rows = cfg_data_i[DimW-1:0];
          cfg_clear        = 1'b1;
        end
        default: begin
          // Drop writes to unknown registers.
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack stage: holds one byte plus leftover bits, emits one pixel a cycle while the result register can take it.
  pgpu_unpack #(
    .MaxGlyphDim (MaxGlyphDim)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_clear_i (cfg_clear),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_final_i  (s_axis_tlast_i),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix)
  );

  // Result register: gray conversion and the m_axis beat.
  pgpu_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> src/pgpu_unpack.sv
`default_nettype none
`include "packed_glyph_pixel_unpacker_core_macros.svh"

module pgpu_unpack
  import pgpu_pkg::*;
#(
  parameter int unsigned MaxGlyphDim = MaxGlyphDimDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             cfg_clear_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [DataW-1:0] in_byte_i,
  input  wire logic             in_final_i,
  output logic                  pix_valid_o,
  input  wire logic             pix_ready_i,
  output pix_t                  pix_o
);

  // Dimension registers are 9 bits wide, so a clamp above 511 never bites.
  localparam int unsigned DimClamp = (MaxGlyphDim > 511) ? 511 : MaxGlyphDim;
  localparam int unsigned ColCntW  = (DimClamp > 1) ? $clog2(DimClamp) : 1;
  localparam int unsigned RowCntW  = $clog2(DimClamp + 1);
  localparam int unsigned CmpW     = DimW + 1;
  localparam logic [DimW-1:0] DimMax = DimW'(DimClamp);

  logic               busy_q, busy_d;
  logic               fin_q, fin_d;
  logic               cmp_q, cmp_d;
  logic [BufW-1:0]    buf_q, buf_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ColCntW-1:0] col_q, col_d;
  logic [RowCntW-1:0] row_q, row_d;

  logic [DimW-1:0]  cols, rows;
  logic [CntW-1:0]  rb;
  logic             emit, whole, more, last, item_end;
  logic [CntW-1:0]  sh_whole, sh_tail, cnt_post;
  logic [BufW-1:0]  whole_raw;
  logic [DataW-1:0] rb_mask, whole_v, tail_v;
  logic [LeftW-1:0] tail_mask;
  logic [CmpW-1:0]  col_nx, row_nx;
  logic             col_wrap, cmp_e;

  // Settled stream state after this cycle's pixel.
  logic               cmp_s;
  logic [CntW-1:0]    cnt_s;
  logic [ColCntW-1:0] col_s;
  logic [RowCntW-1:0] row_s;
  logic               in_fire, skip;
  logic [LeftW-1:0]   left_mask;

  always_comb begin
    cols = (cfg_i.glyph_cols > DimMax) ? DimMax : cfg_i.glyph_cols;
    rows = (cfg_i.glyph_rows > DimMax) ? DimMax : cfg_i.glyph_rows;
    rb   = (cfg_i.depth_code == DEPTH_3 && cfg_i.nibble_aligned_three) ?
           CntW'(4) : pix_bits(cfg_i.depth_code);
  end

  // Pixel extraction: a whole pixel from the top of the buffer, or the
  // zero-padded tail of a final byte.
  always_comb begin
    emit      = busy_q && pix_ready_i;
    whole     = cnt_q >= rb;
    sh_whole  = cnt_q - rb;
    whole_raw = buf_q >> sh_whole;
    rb_mask   = DataW'((9'd1 << rb) - 9'd1);
    whole_v   = whole_raw[DataW-1:0] & rb_mask;
    tail_mask = LeftW'((8'd1 << cnt_q[2:0]) - 8'd1);
    sh_tail   = rb - cnt_q;
    tail_v    = DataW'({1'b0, buf_q[LeftW-1:0] & tail_mask} << sh_tail);
    cnt_post  = whole ? (cnt_q - rb) : '0;

    col_nx   = CmpW'(col_q) + CmpW'(1);
    row_nx   = CmpW'(row_q) + CmpW'(1);
    col_wrap = col_nx >= CmpW'(cols);
    cmp_e    = col_wrap && (row_nx >= CmpW'(rows));

    more     = (cnt_post >= rb) || (fin_q && (cnt_post != '0));
    last     = !more || cmp_e;
    item_end = emit && last;
  end

  always_comb begin
    cmp_s = cmp_q;
    cnt_s = cnt_q;
    col_s = col_q;
    row_s = row_q;
    if (emit) begin
      col_s = col_wrap ? '0 : ColCntW'(col_nx);
      row_s = col_wrap ? RowCntW'(row_nx) : row_q;
      cmp_s = cmp_e;
      cnt_s = cnt_post;
      if (last && (fin_q || cmp_e)) begin
        cnt_s = '0;
      end
      if (last && fin_q) begin
        col_s = '0;
        row_s = '0;
        cmp_s = 1'b0;
      end
    end
  end

  assign in_ready_o = !busy_q || item_end;

  always_comb begin
    in_fire   = in_valid_i && in_ready_o;
    skip      = (cols == '0) || (rows == '0) || cmp_s;
    left_mask = LeftW'((8'd1 << cnt_s[2:0]) - 8'd1);

    busy_d = busy_q && !item_end;
    fin_d  = fin_q;
    buf_d  = buf_q;
    cnt_d  = cnt_s;
    col_d  = col_s;
    row_d  = row_s;
    cmp_d  = cmp_s;

    if (cfg_clear_i) begin
      busy_d = 1'b0;
      cnt_d  = '0;
      col_d  = '0;
      row_d  = '0;
      cmp_d  = 1'b0;
    end else if (in_fire) begin
      if (skip) begin
        // Nothing to emit; a final byte still restarts the glyph.
        if (in_final_i) begin
          cnt_d = '0;
          col_d = '0;
          row_d = '0;
          cmp_d = 1'b0;
        end
      end else begin
        busy_d = 1'b1;
        fin_d  = in_final_i;
        buf_d  = {buf_q[LeftW-1:0] & left_mask, in_byte_i};
        cnt_d  = cnt_s + ByteBits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cmp_q  <= 1'b0;
      cnt_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cmp_q  <= cmp_d;
      cnt_q  <= cnt_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // Leftover bits are meaningful only below cnt_q; no reset needed.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_comb begin
    pix_valid_o      = busy_q;
    pix_o.value      = whole ? whole_v : tail_v;
    pix_o.depth_code = cfg_i.depth_code;
    pix_o.col        = PosW'(col_q);
    pix_o.row        = PosW'(row_q);
    pix_o.run_end    = last;
    pix_o.glyph_end  = cmp_e;
  end

  `PGPU_ASSERT_ALWAYS(a_idle_leftover_short, clk_i, (!busy_q |-> (cnt_q <= LeftMax)))
  `PGPU_ASSERT_ALWAYS(a_busy_not_complete, clk_i, (busy_q |-> !cmp_q))
  `PGPU_ASSERT_ALWAYS(a_complete_at_col0, clk_i, (cmp_q |-> (col_q == '0)))
  `PGPU_ASSERT(a_tail_only_final, clk_i, rst_ni, ((busy_q && !whole) |-> (fin_q && (cnt_q != '0))))

endmodule

`default_nettype wire

>>> src/pgpu_out_stage.sv
`default_nettype none

module pgpu_out_stage
  import pgpu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pix_valid_i,
  output logic                     pix_ready_o,
  input  wire pix_t                pix_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_last_o,
  output logic                     out_user_o
);

  logic                valid_q, valid_d;
  logic [GrayW-1:0]    gray_q;
  logic [PosW-1:0]     col_q, row_q;
  logic                run_q, end_q;
  logic                load;

  assign pix_ready_o = !valid_q || out_ready_i;
  assign load        = pix_valid_i && pix_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Convert to gray on the way into the result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      gray_q <= gray_of(pix_i.value, pix_i.depth_code);
      col_q  <= pix_i.col;
      row_q  <= pix_i.row;
      run_q  <= pix_i.run_end;
      end_q  <= pix_i.glyph_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {row_q, col_q, gray_q};
  assign out_last_o  = end_q;
  assign out_user_o  = run_q;

endmodule

`default_nettype wire
